// ===== rtl/prl_pkg.sv =====
package prl_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned SpaceW  = 16;
  localparam int unsigned LimitW  = 8;
  localparam int unsigned CountW  = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;

  typedef logic [TimeW-1:0]   time_ms_t;
  typedef logic [SpaceW-1:0]  space_t;
  typedef logic [LimitW-1:0]  limit_t;
  typedef logic [CountW-1:0]  count_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  typedef logic [CfgW-1:0]    cfg_data_t;
  typedef logic [1:0]         req_type_t;
  typedef logic [3:0]         level_t;

  // request codes
  localparam req_type_t REQ_LOG       = 2'd0;
  localparam req_type_t REQ_TELEM_ON  = 2'd1;
  localparam req_type_t REQ_TELEM_OFF = 2'd2;
  localparam req_type_t REQ_SPARE     = 2'd3;

  // level codes
  localparam level_t LVL_EMERG   = 4'd0;
  localparam level_t LVL_ALERT   = 4'd1;
  localparam level_t LVL_CRIT    = 4'd2;
  localparam level_t LVL_ERROR   = 4'd3;
  localparam level_t LVL_WARN    = 4'd4;
  localparam level_t LVL_NOTICE  = 4'd5;
  localparam level_t LVL_INFO    = 4'd6;
  localparam level_t LVL_DEBUG   = 4'd7;
  localparam level_t LVL_UNKNOWN = 4'd8;

  // configuration register indexes
  localparam cfg_idx_t CFG_MIN_SPACING = 3'd0;
  localparam cfg_idx_t CFG_WARN_SPACING = 3'd1;
  localparam cfg_idx_t CFG_HOT_SPACING = 3'd2;
  localparam cfg_idx_t CFG_BURST_WINDOW = 3'd3;
  localparam cfg_idx_t CFG_WARN_LIMIT = 3'd4;
  localparam cfg_idx_t CFG_INFO_LIMIT = 3'd5;
  localparam cfg_idx_t CFG_DEBUG_LIMIT = 3'd6;

  // configuration defaults
  localparam space_t RST_MIN_SPACING  = 16'd100;
  localparam space_t RST_WARN_SPACING = 16'd50;
  localparam space_t RST_HOT_SPACING  = 16'd50;
  localparam space_t RST_BURST_WINDOW = 16'd1000;
  localparam limit_t RST_WARN_LIMIT   = 8'd5;
  localparam limit_t RST_INFO_LIMIT   = 8'd3;
  localparam limit_t RST_DEBUG_LIMIT  = 8'd1;

endpackage

// ===== rtl/prl_req_if.sv =====
interface prl_req_if import prl_pkg::*; ();
  logic      valid;
  logic      ready;
  req_type_t req_type;
  time_ms_t  now_ms;
  level_t    level_code;
  logic      hot_content;

  modport source (output valid, req_type, now_ms, level_code, hot_content, input ready);
  modport sink (input valid, req_type, now_ms, level_code, hot_content, output ready);
endinterface

// ===== rtl/prl_res_if.sv =====
interface prl_res_if import prl_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   publish;
  logic   was_critical;
  count_t forwarded_total;
  count_t dropped_total;
  count_t critical_total;

  modport source (output valid, publish, was_critical, forwarded_total, dropped_total,
                  critical_total, input ready);
  modport sink (input valid, publish, was_critical, forwarded_total, dropped_total,
                critical_total, output ready);
endinterface

// ===== rtl/priority_rate_limiter.sv =====
// path: an accepted request waits in the input register and moves on to the result register
// when that register is empty or res.ready is high
// throughput: one request per cycle; the input register and the result register
// advance together, so the only limit is res.ready
// reset: counters, timers and burst count cleared, configuration to its defaults,
// telemetry mode to not-disabled, both pipeline registers empty
module priority_rate_limiter import prl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  cfg_idx_t   cfg_idx,
  input  cfg_data_t  cfg_data,
  prl_req_if.sink    req,
  prl_res_if.source  res
);

  // configuration
  space_t min_spacing, warn_spacing, hot_spacing, burst_window;
  limit_t warn_limit, info_limit, debug_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_spacing  <= RST_MIN_SPACING;
      warn_spacing <= RST_WARN_SPACING;
      hot_spacing  <= RST_HOT_SPACING;
      burst_window <= RST_BURST_WINDOW;
      warn_limit   <= RST_WARN_LIMIT;
      info_limit   <= RST_INFO_LIMIT;
      debug_limit  <= RST_DEBUG_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MIN_SPACING:  min_spacing  <= cfg_data;
        CFG_WARN_SPACING: warn_spacing <= cfg_data;
        CFG_HOT_SPACING:  hot_spacing  <= cfg_data;
        CFG_BURST_WINDOW: burst_window <= cfg_data;
        CFG_WARN_LIMIT:   warn_limit   <= cfg_data[LimitW-1:0];
        CFG_INFO_LIMIT:   info_limit   <= cfg_data[LimitW-1:0];
        CFG_DEBUG_LIMIT:  debug_limit  <= cfg_data[LimitW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic      s1_valid;
  req_type_t s1_type;
  time_ms_t  s1_now;
  level_t    s1_level;
  logic      s1_hot;
  logic      s1_move;

  assign s1_move   = s1_valid && (!res.valid || res.ready);
  assign req.ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      s1_type  <= req.req_type;
      s1_now   <= req.now_ms;
      s1_level <= req.level_code;
      s1_hot   <= req.hot_content;
    end
  end

  // limiter state
  time_ms_t last_pub, burst_start;
  limit_t   burst_used;
  logic     telem_off;
  count_t   fwd_cnt, drop_cnt, crit_cnt;

  // decision
  time_ms_t since, burst_since;
  logic     is_msg, is_crit, is_warn, is_info;
  logic     pub, drop, upd_last, win_restart, burst_inc;
  limit_t   used_eff, limit_sel;

  assign since       = s1_now - last_pub;
  assign burst_since = s1_now - burst_start;
  assign is_msg      = (s1_type == REQ_LOG);
  assign is_crit     = (s1_level <= LVL_ERROR);
  assign is_warn     = (s1_level == LVL_WARN);
  assign is_info     = (s1_level == LVL_NOTICE) || (s1_level == LVL_INFO);
  assign win_restart = burst_since > {{(TimeW-SpaceW){1'b0}}, burst_window};
  assign used_eff    = win_restart ? '0 : burst_used;

  always_comb begin
    priority if (is_warn) limit_sel = warn_limit;
    else if (is_info)     limit_sel = info_limit;
    else                  limit_sel = debug_limit;
  end

  always_comb begin
    pub       = 1'b0;
    drop      = 1'b0;
    burst_inc = 1'b0;
    if (is_msg) begin
      if (is_crit) begin
        pub = 1'b1;
      end else if (!telem_off) begin
        if (s1_hot) begin
          pub = (since >= {{(TimeW-SpaceW){1'b0}}, hot_spacing});
        end else if (since < {{(TimeW-SpaceW){1'b0}}, min_spacing}) begin
          // warnings may undercut the minimum spacing and then skip the burst check
          if (is_warn && since >= {{(TimeW-SpaceW){1'b0}}, warn_spacing}) begin
            pub = 1'b1;
          end else begin
            drop = 1'b1;
          end
        end else if (used_eff >= limit_sel) begin
          drop = 1'b1;
        end else begin
          pub       = 1'b1;
          burst_inc = 1'b1;
        end
      end
    end
    upd_last = pub;
  end

  // the window check happens only on the burst path
  logic   burst_path;
  count_t fwd_next, drop_next, crit_next;

  assign burst_path = is_msg && !is_crit && !telem_off && !s1_hot &&
                      (since >= {{(TimeW-SpaceW){1'b0}}, min_spacing});
  assign fwd_next  = fwd_cnt + (pub ? count_t'(1) : count_t'(0));
  assign drop_next = drop_cnt + (drop ? count_t'(1) : count_t'(0));
  assign crit_next = crit_cnt + ((pub && is_crit) ? count_t'(1) : count_t'(0));

  always_ff @(posedge clk) begin
    if (rst) begin
      last_pub    <= '0;
      burst_start <= '0;
      burst_used  <= '0;
      telem_off   <= 1'b0;
      fwd_cnt     <= '0;
      drop_cnt    <= '0;
      crit_cnt    <= '0;
    end else if (s1_move) begin
      if (s1_type == REQ_TELEM_ON) telem_off <= 1'b0;
      if (s1_type == REQ_TELEM_OFF) telem_off <= 1'b1;
      if (upd_last) last_pub <= s1_now;
      if (burst_path) begin
        if (win_restart) burst_start <= s1_now;
        burst_used <= used_eff + (burst_inc ? limit_t'(1) : limit_t'(0));
      end
      fwd_cnt  <= fwd_next;
      drop_cnt <= drop_next;
      crit_cnt <= crit_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (!res.valid || res.ready) begin
      res.valid <= s1_valid;
    end
    if (s1_move) begin
      res.publish         <= pub;
      res.was_critical    <= pub && is_crit;
      res.forwarded_total <= fwd_next;
      res.dropped_total   <= drop_next;
      res.critical_total  <= crit_next;
    end
  end

  a_crit_implies_pub: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (!res.was_critical || res.publish))
    else $error("was_critical set without publish");

  a_pub_drop_excl: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !(pub && drop))
    else $error("request both published and dropped");

  a_telem_off_blocks: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && is_msg && !is_crit && telem_off) |-> (!pub && !drop))
    else $error("non-critical message passed while telemetry disabled");

  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_move) |=> s1_valid)
    else $error("held request vanished from input register");

  a_move_fills_out: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> res.valid)
    else $error("request advanced but no result presented");

endmodule
